>>> design/vhtl_pkg.sv
package vhtl_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int FRAC_BITS = 16;
  localparam int OFF_W = 18;
  localparam int CELL_W = 20;
  localparam int KEY_W = 3 * CELL_W;
  localparam int SIZE_W = 13;
  localparam int CFG_W = 20;
  localparam int PROD_W = (OFF_W - 1) + CELL_W;

  localparam logic [63:0] MIX_C1 = 64'h7fb5d329728ea185;
  localparam logic [63:0] MIX_C2 = 64'h81dadef4bc2dd44d;

  localparam logic [1:0] REG_VOXELS_X = 2'd0;
  localparam logic [1:0] REG_VOXELS_Y = 2'd1;
  localparam logic [1:0] REG_VOXELS_Z = 2'd2;
  localparam logic [1:0] REG_TABLE_SIZE = 2'd3;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_CLAIMED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] XS_31 = 2'd0;
  localparam logic [1:0] XS_27 = 2'd1;
  localparam logic [1:0] XS_33 = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_CELL_MUL,
    S_CELL_CLAMP,
    S_XS1,
    S_M1A,
    S_M1B,
    S_M1C,
    S_M1D,
    S_XS2,
    S_M2A,
    S_M2B,
    S_M2C,
    S_M2D,
    S_XS3,
    S_DIV_INIT,
    S_DIV,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       clear_wr;
    logic       load_in;
    logic       cell_mul;
    logic       cell_clamp;
    logic       xs_en;
    logic [1:0] xs_sel;
    logic       mul_en;
    logic       mul_hi_a;
    logic       mul_hi_b;
    logic       mul_c2;
    logic       acc_load;
    logic       acc_add;
    logic       h_from_acc;
    logic       div_init;
    logic       div_step;
    logic       probe_init;
    logic       mem_rd;
    logic       probe_finish;
    logic       probe_next;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_last;
    logic hit;
    logic empty;
    logic full;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> design/vhtl_ctrl.sv
module vhtl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  vhtl_pkg::dp_stat_t stat,
  output vhtl_pkg::dp_cmd_t  cmd
);

  vhtl_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vhtl_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      vhtl_pkg::S_CLEAR: if (stat.clear_last) state_next = vhtl_pkg::S_IDLE;
      vhtl_pkg::S_IDLE: if (in_valid) state_next = vhtl_pkg::S_CELL_MUL;
      vhtl_pkg::S_CELL_MUL: state_next = vhtl_pkg::S_CELL_CLAMP;
      vhtl_pkg::S_CELL_CLAMP: state_next = vhtl_pkg::S_XS1;
      vhtl_pkg::S_XS1: state_next = vhtl_pkg::S_M1A;
      vhtl_pkg::S_M1A: state_next = vhtl_pkg::S_M1B;
      vhtl_pkg::S_M1B: state_next = vhtl_pkg::S_M1C;
      vhtl_pkg::S_M1C: state_next = vhtl_pkg::S_M1D;
      vhtl_pkg::S_M1D: state_next = vhtl_pkg::S_XS2;
      vhtl_pkg::S_XS2: state_next = vhtl_pkg::S_M2A;
      vhtl_pkg::S_M2A: state_next = vhtl_pkg::S_M2B;
      vhtl_pkg::S_M2B: state_next = vhtl_pkg::S_M2C;
      vhtl_pkg::S_M2C: state_next = vhtl_pkg::S_M2D;
      vhtl_pkg::S_M2D: state_next = vhtl_pkg::S_XS3;
      vhtl_pkg::S_XS3: state_next = vhtl_pkg::S_DIV_INIT;
      vhtl_pkg::S_DIV_INIT: state_next = vhtl_pkg::S_DIV;
      vhtl_pkg::S_DIV: if (stat.div_last) state_next = vhtl_pkg::S_PROBE_RD;
      vhtl_pkg::S_PROBE_RD: state_next = vhtl_pkg::S_PROBE_CHK;
      vhtl_pkg::S_PROBE_CHK: begin
        if (stat.hit || stat.empty || stat.full) begin
          state_next = vhtl_pkg::S_DONE;
        end else begin
          state_next = vhtl_pkg::S_PROBE_RD;
        end
      end
      vhtl_pkg::S_DONE: if (!stat.out_busy) state_next = vhtl_pkg::S_IDLE;
      default: state_next = vhtl_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      vhtl_pkg::S_CLEAR: cmd.clear_wr = 1'b1;
      vhtl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load_in = in_valid;
      end
      vhtl_pkg::S_CELL_MUL: cmd.cell_mul = 1'b1;
      vhtl_pkg::S_CELL_CLAMP: cmd.cell_clamp = 1'b1;
      vhtl_pkg::S_XS1: begin
        cmd.xs_en = 1'b1;
        cmd.xs_sel = vhtl_pkg::XS_31;
      end
      vhtl_pkg::S_M1A: cmd.mul_en = 1'b1;
      vhtl_pkg::S_M1B: begin
        cmd.mul_en = 1'b1;
        cmd.mul_hi_a = 1'b1;
        cmd.acc_load = 1'b1;
      end
      vhtl_pkg::S_M1C: begin
        cmd.mul_en = 1'b1;
        cmd.mul_hi_b = 1'b1;
        cmd.acc_add = 1'b1;
      end
      vhtl_pkg::S_M1D: cmd.h_from_acc = 1'b1;
      vhtl_pkg::S_XS2: begin
        cmd.xs_en = 1'b1;
        cmd.xs_sel = vhtl_pkg::XS_27;
      end
      vhtl_pkg::S_M2A: begin
        cmd.mul_en = 1'b1;
        cmd.mul_c2 = 1'b1;
      end
      vhtl_pkg::S_M2B: begin
        cmd.mul_en = 1'b1;
        cmd.mul_c2 = 1'b1;
        cmd.mul_hi_a = 1'b1;
        cmd.acc_load = 1'b1;
      end
      vhtl_pkg::S_M2C: begin
        cmd.mul_en = 1'b1;
        cmd.mul_c2 = 1'b1;
        cmd.mul_hi_b = 1'b1;
        cmd.acc_add = 1'b1;
      end
      vhtl_pkg::S_M2D: cmd.h_from_acc = 1'b1;
      vhtl_pkg::S_XS3: begin
        cmd.xs_en = 1'b1;
        cmd.xs_sel = vhtl_pkg::XS_33;
      end
      vhtl_pkg::S_DIV_INIT: cmd.div_init = 1'b1;
      vhtl_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.probe_init = stat.div_last;
      end
      vhtl_pkg::S_PROBE_RD: cmd.mem_rd = 1'b1;
      vhtl_pkg::S_PROBE_CHK: begin
        if (stat.hit || stat.empty || stat.full) begin
          cmd.probe_finish = 1'b1;
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      vhtl_pkg::S_DONE: cmd.out_load = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

>>> design/vhtl_dp.sv
module vhtl_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  vhtl_pkg::dp_cmd_t          cmd,
  output vhtl_pkg::dp_stat_t         stat,
  input  logic                      cfg_wr,
  input  logic [1:0]                cfg_index,
  input  logic [vhtl_pkg::CFG_W-1:0] cfg_data,
  input  logic [vhtl_pkg::OFF_W-1:0] off_x,
  input  logic [vhtl_pkg::OFF_W-1:0] off_y,
  input  logic [vhtl_pkg::OFF_W-1:0] off_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [vhtl_pkg::ADDR_W-1:0] out_slot,
  output logic [1:0]                out_status,
  output logic [vhtl_pkg::SIZE_W-1:0] out_probes,
  output logic [vhtl_pkg::CELL_W-1:0] out_cx,
  output logic [vhtl_pkg::CELL_W-1:0] out_cy,
  output logic [vhtl_pkg::CELL_W-1:0] out_cz
);

  localparam int AW = vhtl_pkg::ADDR_W;
  localparam int CW = vhtl_pkg::CELL_W;
  localparam int SW = vhtl_pkg::SIZE_W;
  localparam int PW = vhtl_pkg::PROD_W;
  localparam int KW = vhtl_pkg::KEY_W;
  localparam int VW = vhtl_pkg::OFF_W - 1;

  logic [CW-1:0] vx, vy, vz;
  logic [SW-1:0] tsize;
  logic [vhtl_pkg::OFF_W-1:0] in_x, in_y, in_z;
  logic [PW-1:0] pr_x, pr_y, pr_z;
  logic [CW-1:0] cx, cy, cz;
  logic [63:0] h, acc, prod;
  logic [SW-1:0] rem;
  logic [5:0] div_cnt;
  logic [AW-1:0] slot, dlt, inc;
  logic [SW-1:0] probes;
  logic [KW:0] rd_data;
  logic [1:0] res_status;
  logic [AW-1:0] clr_addr;
  logic [KW:0] mem [vhtl_pkg::TABLE_DEPTH];

  // effective counts and size
  logic [CW-1:0] nx, ny, nz;
  logic [SW-1:0] size;
  assign nx = (vx == '0) ? CW'(1) : vx;
  assign ny = (vy == '0) ? CW'(1) : vy;
  assign nz = (vz == '0) ? CW'(1) : vz;
  assign size = (tsize == '0) ? SW'(1) :
                (tsize > SW'(vhtl_pkg::TABLE_DEPTH)) ? SW'(vhtl_pkg::TABLE_DEPTH) : tsize;

  always_ff @(posedge clk) begin
    if (rst) begin
      vx <= CW'(1);
      vy <= CW'(1);
      vz <= CW'(1);
      tsize <= SW'(4);
    end else if (cfg_wr) begin
      case (cfg_index)
        vhtl_pkg::REG_VOXELS_X: vx <= cfg_data;
        vhtl_pkg::REG_VOXELS_Y: vy <= cfg_data;
        vhtl_pkg::REG_VOXELS_Z: vz <= cfg_data;
        vhtl_pkg::REG_TABLE_SIZE: tsize <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // offset to cell: negative offsets multiply as zero
  function automatic logic [VW-1:0] mag(input logic [vhtl_pkg::OFF_W-1:0] o);
    return o[vhtl_pkg::OFF_W-1] ? '0 : o[VW-1:0];
  endfunction

  function automatic logic [CW-1:0] clamp(input logic [PW-1:0] p, input logic [CW-1:0] n);
    logic [PW-vhtl_pkg::FRAC_BITS-1:0] q;
    logic [CW-1:0] nm1;
    q = p[PW-1:vhtl_pkg::FRAC_BITS];
    nm1 = n - CW'(1);
    return (q > (PW-vhtl_pkg::FRAC_BITS)'(nm1)) ? nm1 : q[CW-1:0];
  endfunction

  // shared 32x32 multiplier for the two mix rounds
  logic [63:0] mconst;
  logic [31:0] ma, mb;
  assign mconst = cmd.mul_c2 ? vhtl_pkg::MIX_C2 : vhtl_pkg::MIX_C1;
  assign ma = cmd.mul_hi_a ? h[63:32] : h[31:0];
  assign mb = cmd.mul_hi_b ? mconst[63:32] : mconst[31:0];

  logic [63:0] xs_val;
  always_comb begin
    case (cmd.xs_sel)
      vhtl_pkg::XS_31: xs_val = h ^ (h >> 31);
      vhtl_pkg::XS_27: xs_val = h ^ (h >> 27);
      vhtl_pkg::XS_33: xs_val = h ^ (h >> 33);
      default: xs_val = h;
    endcase
  end

  // restoring remainder, one bit per cycle; rem stays below size
  logic [SW-1:0] div_t;
  assign div_t = {rem[SW-2:0], h[63]};

  // quadratic probe: dlt tracks k*k mod size, inc tracks 2k+1 mod size
  logic [SW-1:0] dsum, dn, ssum, snext, isum;
  always_comb begin
    dsum = {1'b0, dlt} + {1'b0, inc};
    dn = (dsum >= size) ? dsum - size : dsum;
    ssum = {1'b0, slot} + dn;
    snext = (ssum >= size) ? ssum - size : ssum;
    isum = {1'b0, inc} + SW'(2);
    if (isum >= size) isum = isum - size;
  end

  logic [KW-1:0] key;
  assign key = {cx, cy, cz};

  logic hit, empty, full;
  assign empty = !rd_data[KW];
  assign hit = rd_data[KW] && (rd_data[KW-1:0] == key);
  assign full = !hit && !empty && (probes == size);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_x <= off_x;
      in_y <= off_y;
      in_z <= off_z;
    end
    if (cmd.cell_mul) begin
      pr_x <= PW'(mag(in_x) * nx);
      pr_y <= PW'(mag(in_y) * ny);
      pr_z <= PW'(mag(in_z) * nz);
    end
    if (cmd.cell_clamp) begin
      cx <= clamp(pr_x, nx);
      cy <= clamp(pr_y, ny);
      cz <= clamp(pr_z, nz);
      h <= {4'b0, clamp(pr_x, nx), clamp(pr_y, ny), clamp(pr_z, nz)};
    end else if (cmd.xs_en) begin
      h <= xs_val;
    end else if (cmd.h_from_acc) begin
      h <= acc + {prod[31:0], 32'b0};
    end else if (cmd.div_step) begin
      h <= {h[62:0], 1'b0};
    end
    if (cmd.mul_en) prod <= ma * mb;
    if (cmd.acc_load) begin
      acc <= prod;
    end else if (cmd.acc_add) begin
      acc <= acc + {prod[31:0], 32'b0};
    end
    if (cmd.div_init) begin
      rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= (div_t >= size) ? div_t - size : div_t;
      div_cnt <= div_cnt + 6'd1;
    end
    if (cmd.probe_init) begin
      slot <= (div_t >= size) ? AW'(div_t - size) : AW'(div_t);
      dlt <= '0;
      inc <= (size == SW'(1)) ? AW'(0) : AW'(1);
      probes <= '0;
    end else if (cmd.probe_next) begin
      slot <= snext[AW-1:0];
      dlt <= dn[AW-1:0];
      inc <= isum[AW-1:0];
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[slot];
      probes <= probes + SW'(1);
    end
    if (cmd.probe_finish) begin
      res_status <= hit ? vhtl_pkg::ST_FOUND :
                    empty ? vhtl_pkg::ST_CLAIMED : vhtl_pkg::ST_FULL;
    end
  end

  // key store with valid bit on top; cleared by a sweep after reset
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      mem[clr_addr] <= '0;
    end else if (cmd.probe_finish && empty) begin
      mem[slot] <= {1'b1, key};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_slot <= (res_status == vhtl_pkg::ST_FULL) ? '0 : slot;
      out_status <= res_status;
      out_probes <= probes;
      out_cx <= cx;
      out_cy <= cy;
      out_cz <= cz;
    end
  end

  assign stat.clear_last = (clr_addr == AW'(vhtl_pkg::TABLE_DEPTH - 1));
  assign stat.div_last = (div_cnt == 6'd63);
  assign stat.hit = hit;
  assign stat.empty = empty;
  assign stat.full = full;
  assign stat.out_busy = out_valid;

endmodule

>>> design/voxel_hash_table_lookup_insert.sv
// Voxel hash table: lookup with insert on a miss.
// Input stream (s_*): one point per transfer, three signed 18-bit offsets
// with 16 fraction bits. Output stream (m_*): one result per input, in order.
// Config channel (cfg_*): register index 0..3 = voxels_x, voxels_y, voxels_z,
// table_size; always ready, write only while the block is idle.
// Each point: voxel cells, then hash mixing on one shared 32x32 multiplier,
// then bit-serial remainder by the table size (a setup step, then one bit a
// cycle), then per probe a key store read, then compare and claim, and last
// the load of the output register. The next input is taken the cycle after
// the result is loaded.
// The key store is a single-port memory, one access per cycle.
// After reset the key store is swept clear, one slot a cycle;
// s_tready stays low during the sweep while config writes are taken.
// If the receiver stalls, the result waits in the output register; one more
// item can be accepted and processed, then the block holds it until the
// output register frees.
module voxel_hash_table_lookup_insert (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,    // off_x, off_y, off_z, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,    // slot, probe_count, cell_x, cell_y, cell_z, zero pad
  output logic [1:0]  m_tuser,    // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  vhtl_pkg::dp_cmd_t cmd;
  vhtl_pkg::dp_stat_t stat;
  logic [11:0] slot;
  logic [12:0] probes;
  logic [19:0] cx, cy, cz;

  assign cfg_ready = 1'b1;

  vhtl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vhtl_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_wr     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .off_x      (s_tdata[17:0]),
    .off_y      (s_tdata[35:18]),
    .off_z      (s_tdata[53:36]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_slot   (slot),
    .out_status (m_tuser),
    .out_probes (probes),
    .out_cx     (cx),
    .out_cy     (cy),
    .out_cz     (cz)
  );

  assign m_tdata = {3'b0, cz, cy, cx, probes, slot};

endmodule

>>> design/vhtl_check.sv
module vhtl_check (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic [1:0]  m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == vhtl_pkg::ST_FOUND || m_tuser == vhtl_pkg::ST_CLAIMED ||
                  m_tuser == vhtl_pkg::ST_FULL))
    else $error("bad status code");

  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == vhtl_pkg::ST_FULL |-> m_tdata[11:0] == 12'd0)
    else $error("full result with nonzero slot");

  a_probes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[24:12] != 13'd0)
    else $error("zero probe count");

endmodule

bind voxel_hash_table_lookup_insert vhtl_check u_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> test/tb_voxel_hash_table_lookup_insert.sv
typedef struct packed {
  logic [11:0] slot;
  logic [1:0]  status;
  logic [12:0] probes;
  logic [19:0] cx;
  logic [19:0] cy;
  logic [19:0] cz;
} voxel_hit_t;

class voxel_table_sb;
  logic [19:0] vox [3];
  logic [12:0] tsize;
  logic [59:0] key_mem [vhtl_pkg::TABLE_DEPTH];
  bit          valid_mem [vhtl_pkg::TABLE_DEPTH];
  voxel_hit_t  expected_hits [$];
  int          mismatches;

  function new();
    vox[0] = 20'd1;
    vox[1] = 20'd1;
    vox[2] = 20'd1;
    tsize = 13'd4;
    mismatches = 0;
    foreach (valid_mem[i]) valid_mem[i] = 1'b0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [19:0] val);
    case (idx)
      vhtl_pkg::REG_VOXELS_X: vox[0] = val;
      vhtl_pkg::REG_VOXELS_Y: vox[1] = val;
      vhtl_pkg::REG_VOXELS_Z: vox[2] = val;
      vhtl_pkg::REG_TABLE_SIZE: tsize = val[12:0];
      default: ;
    endcase
  endfunction

  function logic [19:0] cell_of(logic [17:0] off, logic [19:0] cnt);
    logic [63:0] n;
    logic [63:0] c;
    n = {44'd0, cnt};
    if (n == 0) n = 1;
    if (off[17]) return 20'd0;
    c = ({46'd0, off} * n) >> vhtl_pkg::FRAC_BITS;
    if (c > n - 1) c = n - 1;
    return c[19:0];
  endfunction

  function logic [63:0] scramble(logic [63:0] k);
    logic [63:0] h;
    h = k;
    h = h ^ (h >> 31);
    h = h * vhtl_pkg::MIX_C1;
    h = h ^ (h >> 27);
    h = h * vhtl_pkg::MIX_C2;
    h = h ^ (h >> 33);
    return h;
  endfunction

  function void note_point(logic [17:0] ox, logic [17:0] oy, logic [17:0] oz);
    voxel_hit_t r;
    logic [59:0] key;
    logic [63:0] size, h, stride, probes;
    r.cx = cell_of(ox, vox[0]);
    r.cy = cell_of(oy, vox[1]);
    r.cz = cell_of(oz, vox[2]);
    key = {r.cx, r.cy, r.cz};
    size = {51'd0, tsize};
    if (size == 0) size = 1;
    if (size > vhtl_pkg::TABLE_DEPTH) size = vhtl_pkg::TABLE_DEPTH;
    h = scramble({4'd0, key}) % size;
    stride = 1;
    probes = 0;
    r.slot = '0;
    r.status = vhtl_pkg::ST_FULL;
    while (probes < size) begin
      probes++;
      if (!valid_mem[h]) begin
        valid_mem[h] = 1'b1;
        key_mem[h] = key;
        r.slot = h[11:0];
        r.status = vhtl_pkg::ST_CLAIMED;
        break;
      end
      if (key_mem[h] == key) begin
        r.slot = h[11:0];
        r.status = vhtl_pkg::ST_FOUND;
        break;
      end
      h = (h + stride * stride) % size;
      stride++;
    end
    r.probes = probes[12:0];
    expected_hits.insert(expected_hits.size(), r);
  endfunction

  function void check_result(logic [87:0] data, logic [1:0] user);
    voxel_hit_t e, a;
    a.slot = data[11:0];
    a.probes = data[24:12];
    a.cx = data[44:25];
    a.cy = data[64:45];
    a.cz = data[84:65];
    a.status = user;
    if (expected_hits.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result slot=%0d status=%0d", a.slot, a.status);
      return;
    end
    e = expected_hits.pop_front();
    if (a != e) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: exp slot=%0d st=%0d pr=%0d cell=%0d,%0d,%0d",
                 e.slot, e.status, e.probes, e.cx, e.cy, e.cz);
        $display("          got slot=%0d st=%0d pr=%0d cell=%0d,%0d,%0d",
                 a.slot, a.status, a.probes, a.cx, a.cy, a.cz);
      end
    end
  endfunction

  function int pending();
    return expected_hits.size();
  endfunction
endclass

module tb_voxel_hash_table_lookup_insert;
  localparam int STALL_LIMIT = 40000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  voxel_table_sb sb = new();
  int unsigned cyc = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  voxel_hash_table_lookup_insert DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: check, stall pattern, watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    m_tready <= cyc[9] || ($urandom_range(0, 3) != 0);
    if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(logic [19:0] vx, logic [19:0] vy, logic [19:0] vz, logic [19:0] ts);
    write_reg(vhtl_pkg::REG_VOXELS_X, vx);
    write_reg(vhtl_pkg::REG_VOXELS_Y, vy);
    write_reg(vhtl_pkg::REG_VOXELS_Z, vz);
    write_reg(vhtl_pkg::REG_TABLE_SIZE, ts);
  endtask

  task automatic send_point(logic [17:0] ox, logic [17:0] oy, logic [17:0] oz);
    if (burst_left == 0) begin
      if (!cyc[10]) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, oz, oy, ox};
    do @(posedge clk); while (!s_tready);
    sb.note_point(ox, oy, oz);
    burst_left--;
  endtask

  // stop sending and let the table drain before touching registers
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [17:0] rand_off();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 18'($urandom_range(0, 65535)) | 18'h20000;   // negative
    if (sel == 1) return 18'($urandom_range(65536, 131071));          // one or more
    return 18'($urandom_range(0, 65535));
  endfunction

  task automatic random_phase(int n);
    repeat (n) send_point(rand_off(), rand_off(), rand_off());
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: every point lands in cell 0
    send_point(18'h30000, 18'd0, 18'd65535);
    send_point(18'd131071, 18'd65536, 18'd12345);
    drain();

    // widest grid, single slot: new keys see a full table
    setup(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'd1);
    send_point(18'd0, 18'd0, 18'd0);
    send_point(18'd65535, 18'd65535, 18'd65535);
    send_point(18'd131071, 18'd131071, 18'd131071);
    send_point(18'h30000, 18'h20000, 18'd65536);
    send_point(18'd32768, 18'd1, 18'h3FFFF);
    drain();

    // oversized table clamps to full depth
    setup(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'h01FFF);
    send_point(18'd65535, 18'd65535, 18'd65535);
    send_point(18'd1, 18'd2, 18'd3);
    send_point(18'd65535, 18'd65535, 18'd65535);
    send_point(18'h2AAAA, 18'h15555, 18'd40000);
    drain();

    // zero counts and zero size behave as one
    setup(20'd0, 20'd0, 20'd0, 20'd0);
    send_point(18'd65535, 18'd131071, 18'h30000);
    send_point(18'd0, 18'd0, 18'd0);
    drain();

    setup(20'd3, 20'd2, 20'd5, 20'd16);
    random_phase(120);
    setup(20'd1000, 20'd7, 20'd1, 20'd64);
    random_phase(150);
    setup(20'd50, 20'd50, 20'd50, 20'd1024);
    random_phase(150);
    setup(20'($urandom_range(1, 1048575)), 20'($urandom_range(1, 1048575)),
          20'($urandom_range(1, 1048575)), 20'($urandom_range(1, 256)));
    random_phase(130);

    if (sb.mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
